// File: hdl/sbcf_pkg.sv
// Shared types and constants for the servo bus command framer.
// Used by every module under hdl; depends on nothing else.
package sbcf_pkg;

  localparam logic [2:0] OP_RD_POS   = 3'd0;
  localparam logic [2:0] OP_RD_LOAD  = 3'd1;
  localparam logic [2:0] OP_WR_GOAL  = 3'd2;
  localparam logic [2:0] OP_WR_SPEED = 3'd3;
  localparam logic [2:0] OP_STATUS   = 3'd4;
  localparam logic [2:0] NONE_PENDING = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NACK       = 2'd1;
  localparam logic [1:0] ST_RD_INVALID = 2'd2;
  localparam logic [1:0] ST_NO_CMD     = 2'd3;

  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] REG_POS     = 8'd36;
  localparam logic [7:0] REG_LOAD    = 8'd40;
  localparam logic [7:0] REG_GOAL    = 8'h1E;
  localparam logic [7:0] REG_SPEED   = 8'h20;
  localparam logic [7:0] INSTR_READ  = 8'd2;
  localparam logic [7:0] INSTR_WRITE = 8'd3;
  localparam logic [7:0] LEN_READ    = 8'd4;
  localparam logic [7:0] LEN_WRITE   = 8'd5;
  localparam logic [7:0] READ_SIZE   = 8'd2;

  localparam logic [15:0] POS_MAX  = 16'd1023;
  localparam logic [3:0]  RX_KEEP  = 4'd8;
  localparam logic [3:0]  RX_ERR   = 4'd4;
  localparam logic [3:0]  RX_LO    = 4'd5;
  localparam logic [3:0]  RX_HI    = 4'd6;

  localparam logic [3:0] LAST_RD_IDX = 4'd7;
  localparam logic [3:0] LAST_WR_IDX = 4'd8;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        is_cmd;
    logic [1:0]  cmd;
    logic [7:0]  id;
    logic [15:0] value;
    logic [1:0]  status;
    logic [15:0] read_value;
    logic [7:0]  device_error;
  } job_t;

endpackage

// File: hdl/sbcf_front.sv
// Front end: takes input words, tracks the pending command and status bytes,
// and emits command or verdict jobs. Depends on sbcf_pkg.
module sbcf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [2:0]        opcode_i,
  input  logic [7:0]        servo_id_i,
  input  logic [15:0]       value_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              rx_last_i,
  output logic              job_valid_o,
  output sbcf_pkg::job_t    job_o
);

  logic [2:0]  pend_q, pend_d;
  logic [3:0]  cnt_q, cnt_d, cnt_n;
  logic [7:0]  err_q, err_d, err_n;
  logic [7:0]  lo_q, lo_d, lo_n;
  logic [7:0]  hi_q, hi_d, hi_n;
  logic [15:0] rv_w;
  logic [7:0]  de_w;
  logic [1:0]  st_w;

  always_comb begin
    cnt_n = cnt_q;
    err_n = err_q;
    lo_n  = lo_q;
    hi_n  = hi_q;
    if (cnt_q < sbcf_pkg::RX_KEEP) begin
      if (cnt_q == sbcf_pkg::RX_ERR) err_n = rx_byte_i;
      if (cnt_q == sbcf_pkg::RX_LO)  lo_n  = rx_byte_i;
      if (cnt_q == sbcf_pkg::RX_HI)  hi_n  = rx_byte_i;
      cnt_n = cnt_q + 4'd1;
    end
  end

  always_comb begin
    de_w = (cnt_n >= sbcf_pkg::RX_LO) ? err_n : 8'd0;
    rv_w = 16'd0;
    if (pend_q >= sbcf_pkg::OP_WR_GOAL) begin
      st_w = (cnt_n >= sbcf_pkg::RX_LO && err_n == 8'd0) ? sbcf_pkg::ST_OK
                                                         : sbcf_pkg::ST_NACK;
    end else if (cnt_n < sbcf_pkg::RX_KEEP) begin
      st_w = sbcf_pkg::ST_RD_INVALID;
    end else begin
      rv_w = {hi_n, lo_n};
      st_w = (pend_q == sbcf_pkg::OP_RD_POS && rv_w > sbcf_pkg::POS_MAX) ?
             sbcf_pkg::ST_RD_INVALID : sbcf_pkg::ST_OK;
    end
  end

  always_comb begin
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    job_o.id    = servo_id_i;
    job_o.value = value_i;
    job_o.cmd   = opcode_i[1:0];
    if (accept_i) begin
      if (opcode_i <= sbcf_pkg::OP_WR_SPEED) begin
        job_valid_o  = 1'b1;
        job_o.is_cmd = 1'b1;
        pend_d       = opcode_i;
        cnt_d        = '0;
        err_d        = '0;
        lo_d         = '0;
        hi_d         = '0;
      end else if (opcode_i == sbcf_pkg::OP_STATUS) begin
        if (pend_q == sbcf_pkg::NONE_PENDING) begin
          if (rx_last_i) begin
            job_valid_o  = 1'b1;
            job_o.status = sbcf_pkg::ST_NO_CMD;
          end
        end else if (rx_last_i) begin
          job_valid_o        = 1'b1;
          job_o.status       = st_w;
          job_o.read_value   = rv_w;
          job_o.device_error = de_w;
          pend_d             = sbcf_pkg::NONE_PENDING;
          cnt_d              = '0;
          err_d              = '0;
          lo_d               = '0;
          hi_d               = '0;
        end else begin
          cnt_d = cnt_n;
          err_d = err_n;
          lo_d  = lo_n;
          hi_d  = hi_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= sbcf_pkg::NONE_PENDING;
      cnt_q  <= '0;
      err_q  <= '0;
      lo_q   <= '0;
      hi_q   <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      err_q  <= err_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sbcf_pkg::RX_KEEP) else $error("rx count past limit");
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == sbcf_pkg::NONE_PENDING |-> cnt_q == 4'd0 && err_q == 8'd0)
    else $error("status state kept with nothing pending");
  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= sbcf_pkg::NONE_PENDING) else $error("bad pending code");

endmodule

// File: hdl/sbcf_queue.sv
// Short job queue between front and back end.
// Depends on sbcf_pkg for the job type and depth.
module sbcf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sbcf_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sbcf_pkg::job_t head_o
);

  sbcf_pkg::job_t                mem_q [sbcf_pkg::QDEPTH];
  logic [sbcf_pkg::QPTR_W-1:0]   wr_q, rd_q;
  logic [sbcf_pkg::QCNT_W-1:0]   cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == sbcf_pkg::QCNT_W'(sbcf_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + sbcf_pkg::QCNT_W'(do_push) - sbcf_pkg::QCNT_W'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sbcf_pkg::QCNT_W'(sbcf_pkg::QDEPTH)) else $error("queue overflow");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wr_q == rd_q) else $error("pointers out of step");

endmodule

// File: hdl/sbcf_back.sv
// Back end: expands command jobs into packet bytes with running checksum,
// passes verdict jobs through, and holds the output register. Uses sbcf_pkg.
module sbcf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  sbcf_pkg::job_t head_i,
  output logic           head_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic           kind_o,
  output logic [7:0]     tx_byte_o,
  output logic           last_o,
  output logic [1:0]     status_o,
  output logic [15:0]    read_value_o,
  output logic [7:0]     device_error_o
);

  logic [3:0]  idx_q, idx_d;
  logic [7:0]  sum_q, sum_d;
  logic        ovld_q, ovld_d;
  logic        kind_q, kind_d, last_q, last_d;
  logic [7:0]  tx_q, tx_d, de_q, de_d;
  logic [1:0]  st_q, st_d;
  logic [15:0] rv_q, rv_d;
  logic        is_read, last_byte, advance;
  logic [7:0]  byte_w, addr_w;

  assign is_read   = !head_i.cmd[1];
  assign last_byte = (idx_q == (is_read ? sbcf_pkg::LAST_RD_IDX : sbcf_pkg::LAST_WR_IDX));
  assign advance   = head_valid_i && (!ovld_q || pop_i);

  always_comb begin
    case ({1'b0, head_i.cmd})
      sbcf_pkg::OP_RD_POS:  addr_w = sbcf_pkg::REG_POS;
      sbcf_pkg::OP_RD_LOAD: addr_w = sbcf_pkg::REG_LOAD;
      sbcf_pkg::OP_WR_GOAL: addr_w = sbcf_pkg::REG_GOAL;
      default:              addr_w = sbcf_pkg::REG_SPEED;
    endcase
  end

  always_comb begin
    case (idx_q)
      4'd0, 4'd1: byte_w = sbcf_pkg::HDR_BYTE;
      4'd2:    byte_w = head_i.id;
      4'd3:    byte_w = is_read ? sbcf_pkg::LEN_READ : sbcf_pkg::LEN_WRITE;
      4'd4:    byte_w = is_read ? sbcf_pkg::INSTR_READ : sbcf_pkg::INSTR_WRITE;
      4'd5:    byte_w = addr_w;
      4'd6:    byte_w = is_read ? sbcf_pkg::READ_SIZE : head_i.value[7:0];
      4'd7:    byte_w = is_read ? ~sum_q : head_i.value[15:8];
      4'd8:    byte_w = ~sum_q;
      default: byte_w = '0;
    endcase
  end

  always_comb begin
    idx_d      = idx_q;
    sum_d      = sum_q;
    ovld_d     = ovld_q;
    kind_d     = kind_q;
    tx_d       = tx_q;
    last_d     = last_q;
    st_d       = st_q;
    rv_d       = rv_q;
    de_d       = de_q;
    head_pop_o = 1'b0;
    if (advance) begin
      ovld_d = 1'b1;
      last_d = 1'b1;
      if (head_i.is_cmd) begin
        kind_d = sbcf_pkg::KIND_TX;
        tx_d   = byte_w;
        last_d = last_byte;
        st_d   = sbcf_pkg::ST_OK;
        rv_d   = '0;
        de_d   = '0;
        sum_d  = (idx_q < 4'd2) ? 8'd0 : sum_q + byte_w;
        if (last_byte) begin
          idx_d      = '0;
          head_pop_o = 1'b1;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end else begin
        kind_d     = sbcf_pkg::KIND_VERDICT;
        tx_d       = '0;
        st_d       = head_i.status;
        rv_d       = head_i.read_value;
        de_d       = head_i.device_error;
        idx_d      = '0;
        head_pop_o = 1'b1;
      end
    end else if (pop_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    tx_q   <= tx_d;
    last_q <= last_d;
    st_q   <= st_d;
    rv_q   <= rv_d;
    de_q   <= de_d;
    sum_q  <= sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      ovld_q <= ovld_d;
    end
  end

  assign empty_o        = !ovld_q;
  assign kind_o         = kind_q;
  assign tx_byte_o      = tx_q;
  assign last_o         = last_q;
  assign status_o       = st_q;
  assign read_value_o   = rv_q;
  assign device_error_o = de_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= sbcf_pkg::LAST_WR_IDX) else $error("byte index out of range");
  a_mid_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 4'd0 |-> head_valid_i && head_i.is_cmd)
    else $error("packet head lost mid-frame");
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && kind_q == sbcf_pkg::KIND_VERDICT |-> last_q)
    else $error("verdict word without last");

endmodule

// File: hdl/servo_bus_command_framer_unit.sv
// Servo bus command framer: each command word becomes one framed packet of
// transmit bytes (8 for a read, 9 for a write), and status bytes are checked,
// giving one verdict word on the byte marked rx_last. The front end takes one
// input word per cycle while its 4-entry job queue has room; the back end
// sends one result word per cycle while the output is popped, so a read
// yields 8 words, a write 9 and a verdict 1, set by the byte sequencer in the
// back end. Items that produce no result do not enter the job queue. Depends
// on sbcf_pkg, sbcf_front, sbcf_queue and sbcf_back.
module servo_bus_command_framer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  servo_id_i,
  input  logic [15:0] value_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  output logic [15:0] read_value_o,
  output logic [7:0]  device_error_o
);

  logic           accept, job_valid, head_valid, head_pop;
  sbcf_pkg::job_t job, head;

  assign accept = push && !full;

  sbcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (opcode_i),
    .servo_id_i  (servo_id_i),
    .value_i     (value_i),
    .rx_byte_i   (rx_byte_i),
    .rx_last_i   (rx_last_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  sbcf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_valid),
    .push_job_i (job),
    .full_o     (full),
    .pop_i      (head_pop),
    .valid_o    (head_valid),
    .head_o     (head)
  );

  sbcf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .head_pop_o     (head_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .kind_o         (kind_o),
    .tx_byte_o      (tx_byte_o),
    .last_o         (last_o),
    .status_o       (status_o),
    .read_value_o   (read_value_o),
    .device_error_o (device_error_o)
  );

endmodule
